[rtl/tcpb_pkg.sv]
// ----------------------------------------------------------------------------
// tcpb_pkg
// Types, register map, mode codes and channel arithmetic for the texture
// combine pixel bake unit.
// ----------------------------------------------------------------------------
package tcpb_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned IdxLsb = 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned ChA    = 0;

  localparam logic [31:0] MaterialReset = 32'hFFFF_FFFF;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] msum_t;
  typedef logic [NumCh-1:0][7:0] pix_t;

  typedef struct packed {
    logic [7:0] tex_r;
    logic [7:0] tex_g;
    logic [7:0] tex_b;
    logic [7:0] tex_a;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
    logic [7:0] out_a;
  } out_word_t;

  typedef struct packed {
    logic [31:0] material_color;
    logic [3:0]  color_map;
    logic [3:0]  alpha_map;
    logic [7:0]  blend_factor;
    logic [1:0]  tev_enable;
    logic [31:0] tev_base;
    logic [31:0] tev_const;
    logic [3:0]  tev_scale;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    material_color: MaterialReset,
    color_map:      4'd0,
    alpha_map:      4'd0,
    blend_factor:   8'd0,
    tev_enable:     2'd0,
    tev_base:       32'd0,
    tev_const:      32'd0,
    tev_scale:      4'd0
  };

  typedef enum logic [2:0] {
    REG_MATERIAL_COLOR,
    REG_COLOR_MAP,
    REG_ALPHA_MAP,
    REG_BLEND_FACTOR,
    REG_TEV_ENABLE,
    REG_TEV_BASE,
    REG_TEV_CONST,
    REG_TEV_SCALE
  } reg_idx_t;

  localparam logic [3:0] CMAP_PASS       = 4'd0;
  localparam logic [3:0] CMAP_ALPHA_MASK = 4'd1;
  localparam logic [3:0] CMAP_RGB_MASK   = 4'd2;
  localparam logic [3:0] CMAP_BLEND      = 4'd3;
  localparam logic [3:0] CMAP_MODULATE   = 4'd4;
  localparam logic [3:0] CMAP_REPLACE    = 4'd5;
  localparam logic [3:0] CMAP_PASS_ALT   = 4'd6;
  localparam logic [3:0] CMAP_ADD        = 4'd7;
  localparam logic [3:0] CMAP_SUB        = 4'd8;

  localparam logic [3:0] AMAP_PASS       = 4'd0;
  localparam logic [3:0] AMAP_MASK       = 4'd1;
  localparam logic [3:0] AMAP_BLEND      = 4'd2;
  localparam logic [3:0] AMAP_MODULATE   = 4'd3;
  localparam logic [3:0] AMAP_REPLACE    = 4'd4;
  localparam logic [3:0] AMAP_PASS_ALT   = 4'd5;
  localparam logic [3:0] AMAP_ADD        = 4'd6;
  localparam logic [3:0] AMAP_SUB        = 4'd7;

  localparam logic [1:0] SCALE_X1   = 2'd0;
  localparam logic [1:0] SCALE_X2   = 2'd1;
  localparam logic [1:0] SCALE_X4   = 2'd2;
  localparam logic [1:0] SCALE_HALF = 2'd3;

  // a*(255-c) + b*c + 127, at most 65152
  function automatic msum_t mix_sum(chan_t a, chan_t b, chan_t c);
    msum_t pa;
    msum_t pb;
    pa = {8'd0, a} * {8'd0, ~c};
    pb = {8'd0, b} * {8'd0, c};
    return pa + pb + 16'd127;
  endfunction

  // exact floor(x / 255) for x below 65280
  function automatic chan_t div255(msum_t x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic chan_t scale8(chan_t v, logic [1:0] sel);
    logic [9:0] w;
    case (sel)
      SCALE_X2:   w = {1'b0, v, 1'b0};
      SCALE_X4:   w = {v, 2'b00};
      SCALE_HALF: w = {2'b00, 8'(({1'b0, v} + 9'd1) >> 1)};
      default:    w = {2'b00, v};
    endcase
    return (w > 10'd255) ? 8'hFF : w[7:0];
  endfunction

  function automatic chan_t sat_add(chan_t a, chan_t b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic chan_t sat_sub(chan_t a, chan_t b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

endpackage

[rtl/texture_combine_pixel_bake_unit.sv]
// ----------------------------------------------------------------------------
// texture_combine_pixel_bake_unit
// Per-texel combiner stage and material color/alpha map, four-stage pipeline.
//
//   channel   ports                        word
//   input     in_valid/in_ready/in_data    one RGBA8 texel
//   result    out_valid/out_ready/out_data one RGBA8 pixel
//   config    APB psel..pready             one 32-bit register
//
// One word per cycle sustained while out_ready stays high; out_valid rises once
// an accepted word has passed the stage 1 to stage 4 registers in order.
// Stages: combiner products, divide/scale/select, map products, divide/select.
// Each stage holds only when the stage after it is full and holding.
// Reset (rst_n low, synchronous) empties the pipeline and loads register
// reset values.
// ----------------------------------------------------------------------------
module texture_combine_pixel_bake_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcpb_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcpb_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcpb_pkg::AddrW-1:0]    paddr,
  input  logic [tcpb_pkg::DataW-1:0]    pwdata,
  output logic [tcpb_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  tcpb_pkg::cfg_t cfg;

  tcpb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcpb_pkg::pix_t mat;
  tcpb_pkg::pix_t base;
  tcpb_pkg::pix_t cnst;
  tcpb_pkg::pix_t tex;
  logic           bypass;

  assign mat  = cfg.material_color;
  assign base = cfg.tev_base;
  assign cnst = cfg.tev_const;
  assign tex  = in_data;

  always_comb begin
    bypass = (cfg.tev_enable == 2'd0) &&
             (cfg.color_map inside {tcpb_pkg::CMAP_MODULATE, tcpb_pkg::CMAP_REPLACE}) &&
             (cfg.alpha_map inside {tcpb_pkg::AMAP_MODULATE, tcpb_pkg::AMAP_REPLACE});
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: combiner products
  tcpb_pkg::pix_t                       tex1_r;
  tcpb_pkg::msum_t [tcpb_pkg::NumCh-1:0] csum1_r;
  tcpb_pkg::msum_t [tcpb_pkg::NumCh-1:0] csum1_nxt;

  always_comb begin
    for (int ch = 0; ch < tcpb_pkg::NumCh; ch++) begin
      csum1_nxt[ch] = tcpb_pkg::mix_sum(base[ch], cnst[ch], tex[ch]);
    end
  end

  // stage 2: divide, scale, select source
  tcpb_pkg::pix_t src2_r;
  tcpb_pkg::pix_t src2_nxt;

  always_comb begin
    for (int ch = 0; ch < tcpb_pkg::NumCh; ch++) begin
      if (ch == tcpb_pkg::ChA) begin
        src2_nxt[ch] = cfg.tev_enable[1] ?
          tcpb_pkg::scale8(tcpb_pkg::div255(csum1_r[ch]), cfg.tev_scale[3:2]) : tex1_r[ch];
      end else begin
        src2_nxt[ch] = cfg.tev_enable[0] ?
          tcpb_pkg::scale8(tcpb_pkg::div255(csum1_r[ch]), cfg.tev_scale[1:0]) : tex1_r[ch];
      end
    end
  end

  // stage 3: map products and direct results
  tcpb_pkg::pix_t                        src3_r;
  tcpb_pkg::pix_t                        dir3_r;
  tcpb_pkg::pix_t                        dir3_nxt;
  tcpb_pkg::msum_t [tcpb_pkg::NumCh-1:0] msum3_r;
  tcpb_pkg::msum_t [tcpb_pkg::NumCh-1:0] msum3_nxt;
  logic [tcpb_pkg::NumCh-1:0]            mix3_r;
  logic [tcpb_pkg::NumCh-1:0]            mix3_nxt;

  always_comb begin
    tcpb_pkg::chan_t ma;
    tcpb_pkg::chan_t mb;
    tcpb_pkg::chan_t mc;
    tcpb_pkg::chan_t s;
    for (int ch = 0; ch < tcpb_pkg::NumCh; ch++) begin
      s            = src2_r[ch];
      ma           = mat[ch];
      mb           = s;
      mc           = s;
      mix3_nxt[ch] = 1'b0;
      dir3_nxt[ch] = 8'd0;
      if (ch == tcpb_pkg::ChA) begin
        case (cfg.alpha_map)
          tcpb_pkg::AMAP_PASS, tcpb_pkg::AMAP_PASS_ALT: dir3_nxt[ch] = mat[ch];
          tcpb_pkg::AMAP_MASK:  mix3_nxt[ch] = 1'b1;
          tcpb_pkg::AMAP_BLEND: begin
            mix3_nxt[ch] = 1'b1;
            mc           = cfg.blend_factor;
          end
          tcpb_pkg::AMAP_MODULATE: begin
            mix3_nxt[ch] = 1'b1;
            ma           = 8'd0;
            mb           = mat[ch];
          end
          tcpb_pkg::AMAP_REPLACE: dir3_nxt[ch] = s;
          tcpb_pkg::AMAP_ADD:     dir3_nxt[ch] = tcpb_pkg::sat_add(mat[ch], s);
          tcpb_pkg::AMAP_SUB:     dir3_nxt[ch] = tcpb_pkg::sat_sub(mat[ch], s);
          default:                dir3_nxt[ch] = 8'd0;
        endcase
      end else begin
        case (cfg.color_map)
          tcpb_pkg::CMAP_PASS, tcpb_pkg::CMAP_PASS_ALT: dir3_nxt[ch] = mat[ch];
          tcpb_pkg::CMAP_ALPHA_MASK: begin
            mix3_nxt[ch] = 1'b1;
            mc           = src2_r[tcpb_pkg::ChA];
          end
          tcpb_pkg::CMAP_RGB_MASK: mix3_nxt[ch] = 1'b1;
          tcpb_pkg::CMAP_BLEND: begin
            mix3_nxt[ch] = 1'b1;
            mc           = cfg.blend_factor;
          end
          tcpb_pkg::CMAP_MODULATE: begin
            mix3_nxt[ch] = 1'b1;
            ma           = 8'd0;
            mb           = mat[ch];
          end
          tcpb_pkg::CMAP_REPLACE: dir3_nxt[ch] = s;
          tcpb_pkg::CMAP_ADD:     dir3_nxt[ch] = tcpb_pkg::sat_add(mat[ch], s);
          tcpb_pkg::CMAP_SUB:     dir3_nxt[ch] = tcpb_pkg::sat_sub(mat[ch], s);
          default:                dir3_nxt[ch] = 8'd0;
        endcase
      end
      msum3_nxt[ch] = tcpb_pkg::mix_sum(ma, mb, mc);
    end
  end

  // stage 4: divide, final select
  tcpb_pkg::pix_t out4_r;
  tcpb_pkg::pix_t out4_nxt;

  always_comb begin
    for (int ch = 0; ch < tcpb_pkg::NumCh; ch++) begin
      if (bypass) begin
        out4_nxt[ch] = src3_r[ch];
      end else if (mix3_r[ch]) begin
        out4_nxt[ch] = tcpb_pkg::div255(msum3_r[ch]);
      end else begin
        out4_nxt[ch] = dir3_r[ch];
      end
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tex1_r  <= tex;
      csum1_r <= csum1_nxt;
    end
    if (en2) begin
      src2_r <= src2_nxt;
    end
    if (en3) begin
      src3_r  <= src2_r;
      dir3_r  <= dir3_nxt;
      msum3_r <= msum3_nxt;
      mix3_r  <= mix3_nxt;
    end
    if (en4) begin
      out4_r <= out4_nxt;
    end
  end

endmodule

[rtl/tcpb_regs.sv]
// ----------------------------------------------------------------------------
// tcpb_regs
// APB register file holding the combiner and material configuration.
// ----------------------------------------------------------------------------
module tcpb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcpb_pkg::AddrW-1:0]    paddr,
  input  logic [tcpb_pkg::DataW-1:0]    pwdata,
  output logic [tcpb_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output tcpb_pkg::cfg_t                cfg
);

  tcpb_pkg::cfg_t   cfg_r;
  tcpb_pkg::cfg_t   cfg_nxt;
  tcpb_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = tcpb_pkg::reg_idx_t'(paddr[tcpb_pkg::AddrW-1:tcpb_pkg::IdxLsb]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        tcpb_pkg::REG_MATERIAL_COLOR: cfg_nxt.material_color = pwdata;
        tcpb_pkg::REG_COLOR_MAP:      cfg_nxt.color_map      = pwdata[3:0];
        tcpb_pkg::REG_ALPHA_MAP:      cfg_nxt.alpha_map      = pwdata[3:0];
        tcpb_pkg::REG_BLEND_FACTOR:   cfg_nxt.blend_factor   = pwdata[7:0];
        tcpb_pkg::REG_TEV_ENABLE:     cfg_nxt.tev_enable     = pwdata[1:0];
        tcpb_pkg::REG_TEV_BASE:       cfg_nxt.tev_base       = pwdata;
        tcpb_pkg::REG_TEV_CONST:      cfg_nxt.tev_const      = pwdata;
        tcpb_pkg::REG_TEV_SCALE:      cfg_nxt.tev_scale      = pwdata[3:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tcpb_pkg::REG_MATERIAL_COLOR: prdata = cfg_r.material_color;
      tcpb_pkg::REG_COLOR_MAP:      prdata = {28'd0, cfg_r.color_map};
      tcpb_pkg::REG_ALPHA_MAP:      prdata = {28'd0, cfg_r.alpha_map};
      tcpb_pkg::REG_BLEND_FACTOR:   prdata = {24'd0, cfg_r.blend_factor};
      tcpb_pkg::REG_TEV_ENABLE:     prdata = {30'd0, cfg_r.tev_enable};
      tcpb_pkg::REG_TEV_BASE:       prdata = cfg_r.tev_base;
      tcpb_pkg::REG_TEV_CONST:      prdata = cfg_r.tev_const;
      tcpb_pkg::REG_TEV_SCALE:      prdata = {28'd0, cfg_r.tev_scale};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tcpb_pkg::CfgReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/tcpb_checker.sv]
// ----------------------------------------------------------------------------
// tcpb_checker
// Port-level checks for the texture combine pixel bake unit, bound to the top.
// ----------------------------------------------------------------------------
module tcpb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input tcpb_pkg::out_word_t        out_data,
  input logic                       pready
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // drop all words in reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // accept input whenever the output stage is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind texture_combine_pixel_bake_unit tcpb_checker u_tcpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

[verif/texture_combine_pixel_bake_unit_tb.sv]
// ----------------------------------------------------------------------------
// texture_combine_pixel_bake_unit_tb
// Drives RGBA8 texels into the bake unit over valid/ready, programs the
// register file over APB while the pipeline is empty, and checks every
// output pixel channel by channel against a local color/alpha combine model.
// Directed checks cover reset values, the bypass path, every map code and
// every combiner scale; random traffic then runs under four idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module texture_combine_pixel_bake_unit_tb;
  import tcpb_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int ItemsPerSet = 25;
  localparam int SetsPerPhase = 5;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic      pready;

  cfg_t      shadow_regs;
  out_word_t pending_pixels[$];
  int        mismatch_count;
  int        pixels_checked;
  int        settings_used;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        quiet_cycles;

  texture_combine_pixel_bake_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned rgba_chan(logic [31:0] w, int c);
    return w[31-8*c -: 8];
  endfunction

  function automatic int unsigned lerp8(int unsigned a, int unsigned b, int unsigned c);
    return (a * (255 - c) + b * c + 127) / 255;
  endfunction

  function automatic int unsigned scale_chan(int unsigned v, logic [1:0] sel);
    int unsigned w;
    case (sel)
      SCALE_X2:   w = v * 2;
      SCALE_X4:   w = v * 4;
      SCALE_HALF: w = (v + 1) / 2;
      default:    w = v;
    endcase
    return (w > 255) ? 255 : w;
  endfunction

  function automatic out_word_t bake_pixel(in_word_t t);
    int unsigned tex[4];
    int unsigned src[4];
    int unsigned mat[4];
    int unsigned res[4];
    out_word_t   px;
    tex[0] = t.tex_r;
    tex[1] = t.tex_g;
    tex[2] = t.tex_b;
    tex[3] = t.tex_a;
    if (shadow_regs.tev_enable == 2'd0 &&
        (shadow_regs.color_map == CMAP_MODULATE || shadow_regs.color_map == CMAP_REPLACE) &&
        (shadow_regs.alpha_map == AMAP_MODULATE || shadow_regs.alpha_map == AMAP_REPLACE)) begin
      px = t;
      return px;
    end
    for (int c = 0; c < 4; c++) begin
      src[c] = tex[c];
      mat[c] = rgba_chan(shadow_regs.material_color, c);
    end
    if (shadow_regs.tev_enable[0]) begin
      for (int c = 0; c < 3; c++)
        src[c] = scale_chan(lerp8(rgba_chan(shadow_regs.tev_base, c),
                                  rgba_chan(shadow_regs.tev_const, c), tex[c]),
                            shadow_regs.tev_scale[1:0]);
    end
    if (shadow_regs.tev_enable[1])
      src[3] = scale_chan(lerp8(rgba_chan(shadow_regs.tev_base, 3),
                                rgba_chan(shadow_regs.tev_const, 3), tex[3]),
                          shadow_regs.tev_scale[3:2]);
    for (int c = 0; c < 3; c++) begin
      case (shadow_regs.color_map)
        CMAP_PASS, CMAP_PASS_ALT: res[c] = mat[c];
        CMAP_ALPHA_MASK: res[c] = lerp8(mat[c], src[c], src[3]);
        CMAP_RGB_MASK:   res[c] = lerp8(mat[c], src[c], src[c]);
        CMAP_BLEND:      res[c] = lerp8(mat[c], src[c], shadow_regs.blend_factor);
        CMAP_MODULATE:   res[c] = lerp8(0, mat[c], src[c]);
        CMAP_REPLACE:    res[c] = src[c];
        CMAP_ADD:        res[c] = (mat[c] + src[c] > 255) ? 255 : mat[c] + src[c];
        CMAP_SUB:        res[c] = (mat[c] > src[c]) ? mat[c] - src[c] : 0;
        default:         res[c] = 0;
      endcase
    end
    case (shadow_regs.alpha_map)
      AMAP_PASS, AMAP_PASS_ALT: res[3] = mat[3];
      AMAP_MASK:     res[3] = lerp8(mat[3], src[3], src[3]);
      AMAP_BLEND:    res[3] = lerp8(mat[3], src[3], shadow_regs.blend_factor);
      AMAP_MODULATE: res[3] = lerp8(0, mat[3], src[3]);
      AMAP_REPLACE:  res[3] = src[3];
      AMAP_ADD:      res[3] = (mat[3] + src[3] > 255) ? 255 : mat[3] + src[3];
      AMAP_SUB:      res[3] = (mat[3] > src[3]) ? mat[3] - src[3] : 0;
      default:       res[3] = 0;
    endcase
    px.out_r = 8'(res[0]);
    px.out_g = 8'(res[1]);
    px.out_b = 8'(res[2]);
    px.out_a = 8'(res[3]);
    return px;
  endfunction

  function automatic logic [7:0] random_chan();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic in_word_t random_texel();
    in_word_t t;
    t.tex_r = random_chan();
    t.tex_g = random_chan();
    t.tex_b = random_chan();
    t.tex_a = random_chan();
    return t;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MATERIAL_COLOR: shadow_regs.material_color = val;
      REG_COLOR_MAP:      shadow_regs.color_map      = val[3:0];
      REG_ALPHA_MAP:      shadow_regs.alpha_map      = val[3:0];
      REG_BLEND_FACTOR:   shadow_regs.blend_factor   = val[7:0];
      REG_TEV_ENABLE:     shadow_regs.tev_enable     = val[1:0];
      REG_TEV_BASE:       shadow_regs.tev_base       = val;
      REG_TEV_CONST:      shadow_regs.tev_const      = val;
      REG_TEV_SCALE:      shadow_regs.tev_scale      = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_texel(in_word_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(bake_pixel(t));
  endtask

  // hold off new words until the pipeline has drained
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_texel(32'h0000_0000);
    send_texel(32'hFFFF_FFFF);
    send_texel(32'h5AA5_C33C);
    wait_drained();
  endtask

  task automatic test_bypass();
    logic [3:0] cmaps[2];
    logic [3:0] amaps[2];
    cmaps = '{CMAP_MODULATE, CMAP_REPLACE};
    amaps = '{AMAP_MODULATE, AMAP_REPLACE};
    write_reg(REG_MATERIAL_COLOR, 32'h2040_6080);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        write_reg(REG_COLOR_MAP, 32'(cmaps[i]));
        write_reg(REG_ALPHA_MAP, 32'(amaps[j]));
        send_texel(in_word_t'({8'(i * 255), 8'(j * 255), 8'h7F, 8'h81}));
        wait_drained();
      end
    end
  endtask

  task automatic test_map_modes();
    int unsigned codes[11];
    codes = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15};
    write_reg(REG_MATERIAL_COLOR, 32'h80C0_40A0);
    write_reg(REG_BLEND_FACTOR, 32'h60);
    write_reg(REG_TEV_ENABLE, 32'h0);
    foreach (codes[k]) begin
      write_reg(REG_COLOR_MAP, 32'(codes[k]));
      write_reg(REG_ALPHA_MAP, 32'(codes[k]));
      send_texel(32'hFF10_E070);
      wait_drained();
    end
  endtask

  task automatic test_combiner_stage();
    write_reg(REG_TEV_BASE, 32'h0010_20FF);
    write_reg(REG_TEV_CONST, 32'hFFF0_8000);
    write_reg(REG_COLOR_MAP, 32'(CMAP_REPLACE));
    write_reg(REG_ALPHA_MAP, 32'(AMAP_REPLACE));
    write_reg(REG_TEV_ENABLE, 32'h3);
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_TEV_SCALE, 32'({2'(s), 2'(s)}));
      send_texel(32'h80FF_0040);
      wait_drained();
    end
    write_reg(REG_COLOR_MAP, 32'(CMAP_ALPHA_MASK));
    write_reg(REG_TEV_ENABLE, 32'h1);
    send_texel(32'hFF00_80FF);
    wait_drained();
    write_reg(REG_TEV_ENABLE, 32'h2);
    send_texel(32'h00FF_8000);
    wait_drained();
  endtask

  task automatic load_random_regs(int flavor);
    logic [31:0] vals[8];
    for (int i = 0; i < 8; i++)
      vals[i] = (flavor == 0) ? 32'h0 : (flavor == 1) ? 32'hFFFF_FFFF : $urandom;
    if (flavor > 1) begin
      vals[REG_COLOR_MAP] = ($urandom_range(11) > 9) ? $urandom_range(15, 9) : $urandom_range(9);
      vals[REG_ALPHA_MAP] = ($urandom_range(10) > 8) ? $urandom_range(15, 8) : $urandom_range(8);
      if ($urandom_range(5) == 0) begin
        vals[REG_TEV_ENABLE] = 32'h0;
        vals[REG_COLOR_MAP]  = $urandom_range(5, 4);
        vals[REG_ALPHA_MAP]  = $urandom_range(4, 3);
      end
    end
    for (int i = 0; i < 8; i++)
      write_reg(reg_idx_t'(i), vals[i]);
    settings_used++;
  endtask

  task automatic test_random_traffic();
    int idle_mix[4][2];
    idle_mix = '{'{0, 0}, '{81, 0}, '{0, 81}, '{8, 8}};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_mix[ph][0];
      recv_stall_pct = idle_mix[ph][1];
      for (int k = 0; k < SetsPerPhase; k++) begin
        load_random_regs((ph == 0) ? k : k + 2);
        repeat (ItemsPerSet) send_texel(random_texel());
        wait_drained();
      end
    end
  endtask

  task automatic compare_chan(string tag, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, tag, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (rst_n)
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_pixels
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: pixel %08h arrived with none expected", $time, out_data);
      end else begin
        want = pending_pixels.pop_front();
        compare_chan("red", want.out_r, out_data.out_r);
        compare_chan("green", want.out_g, out_data.out_g);
        compare_chan("blue", want.out_b, out_data.out_b);
        compare_chan("alpha", want.out_a, out_data.out_a);
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout after %0d cycles with no transfer", QuietLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    pixels_checked = 0;
    settings_used  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    shadow_regs    = '0;
    shadow_regs.material_color = MaterialReset;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_bypass();
    test_map_modes();
    test_combiner_stage();
    test_random_traffic();

    wait_drained();
    $display("Checked %0d pixels across %0d random register settings plus directed cases:",
             pixels_checked, settings_used);
    $display("every map code, combiner scales, bypass, and four idle/stall mixes.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tcpb_pkg.sv
rtl/tcpb_regs.sv
rtl/texture_combine_pixel_bake_unit.sv
rtl/tcpb_checker.sv
verif/texture_combine_pixel_bake_unit_tb.sv
